>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/bqn_pkg.sv
package bqn_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 24;
   localparam int HIST_W    = 32;
   localparam int NUM_COEFS = 5;
   localparam int CSR_IDX_W = 3;

   localparam int DEF_COEF_FRAC_BITS = 22;
   localparam int DEF_HIST_FRAC_BITS = 8;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [HIST_W-1:0]   HIST_MAX   = {1'b0, {(HIST_W-1){1'b1}}};
   localparam logic signed [HIST_W-1:0]   HIST_MIN   = {1'b1, {(HIST_W-1){1'b0}}};
   localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_set_type;

   typedef struct packed {
      logic advance;
      logic clear;
   } step_ctl_type;

endpackage

>>> rtl/bqn_coef_regs.sv
module bqn_coef_regs #(
   parameter int COEF_FRAC_BITS = bqn_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [bqn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bqn_pkg::COEF_W-1:0]          csr_data,
   output bqn_pkg::coef_set_type               coefs
);

   localparam logic signed [bqn_pkg::COEF_W-1:0] B0Reset =
      (COEF_FRAC_BITS >= bqn_pkg::COEF_W - 1) ? bqn_pkg::COEF_MAX
                                              : bqn_pkg::COEF_W'(1 << COEF_FRAC_BITS);

   bqn_pkg::coef_set_type coefs_ff;
   bqn_pkg::coef_set_type coefs_in;

   always_comb begin
      coefs_in = coefs_ff;
      if (csr_write_enable) begin
         case (csr_index)
            bqn_pkg::CSR_B0: coefs_in.b0 = csr_data;
            bqn_pkg::CSR_B1: coefs_in.b1 = csr_data;
            bqn_pkg::CSR_B2: coefs_in.b2 = csr_data;
            bqn_pkg::CSR_A1: coefs_in.a1 = csr_data;
            bqn_pkg::CSR_A2: coefs_in.a2 = csr_data;
            default:         coefs_in = coefs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.b0 <= B0Reset;
         coefs_ff.b1 <= '0;
         coefs_ff.b2 <= '0;
         coefs_ff.a1 <= '0;
         coefs_ff.a2 <= '0;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   assign coefs = coefs_ff;

endmodule

>>> rtl/bqn_core.sv
`include "assert_macros.svh"

module bqn_core #(
   parameter int COEF_FRAC_BITS = bqn_pkg::DEF_COEF_FRAC_BITS,
   parameter int HIST_FRAC_BITS = bqn_pkg::DEF_HIST_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bqn_pkg::coef_set_type                coefs,
   input  bqn_pkg::step_ctl_type                step,
   input  logic signed [bqn_pkg::SAMPLE_W-1:0]  sample_x,
   output logic signed [bqn_pkg::SAMPLE_W-1:0]  sample_y,
   output logic                                 clipped
);

   localparam int SW     = bqn_pkg::SAMPLE_W;
   localparam int CW     = bqn_pkg::COEF_W;
   localparam int HW     = bqn_pkg::HIST_W;
   localparam int FfW    = CW + SW + 2;
   localparam int FbW    = CW + HW + 1;
   localparam int AccW   = 58 + HIST_FRAC_BITS;
   localparam int YShift = COEF_FRAC_BITS + HIST_FRAC_BITS;
   localparam logic [AccW-1:0] HistBias = {{(AccW-COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}};
   localparam logic [AccW-1:0] OutBias  = {{(AccW-YShift){1'b0}}, {YShift{1'b1}}};

   logic signed [SW-1:0] past_in_one_ff, past_in_two_ff;
   logic signed [HW-1:0] past_out_one_ff, past_out_two_ff;

   logic signed [SW-1:0]    x1_eff, x2_eff;
   logic signed [HW-1:0]    y1_eff, y2_eff;
   logic signed [CW+SW-1:0] prod_b0, prod_b1, prod_b2;
   logic signed [CW+HW-1:0] prod_a1, prod_a2;
   logic signed [FfW-1:0]   ff_sum;
   logic signed [FbW-1:0]   fb_sum;
   logic signed [AccW-1:0]  acc, acc_h, acc_y, q_hist, q_out;
   logic [AccW-HW:0]        hist_top;
   logic [AccW-SW:0]        out_top;
   logic                    hist_ok, out_ok;
   logic signed [HW-1:0]    hist_sat;

   assign x1_eff = step.clear ? '0 : past_in_one_ff;
   assign x2_eff = step.clear ? '0 : past_in_two_ff;
   assign y1_eff = step.clear ? '0 : past_out_one_ff;
   assign y2_eff = step.clear ? '0 : past_out_two_ff;

   assign prod_b0 = coefs.b0 * sample_x;
   assign prod_b1 = coefs.b1 * x1_eff;
   assign prod_b2 = coefs.b2 * x2_eff;
   assign prod_a1 = coefs.a1 * y1_eff;
   assign prod_a2 = coefs.a2 * y2_eff;

   assign ff_sum = FfW'(prod_b0) + FfW'(prod_b1) + FfW'(prod_b2);
   assign fb_sum = FbW'(prod_a1) + FbW'(prod_a2);
   assign acc    = (AccW'(ff_sum) <<< HIST_FRAC_BITS) - AccW'(fb_sum);

   // truncate toward zero: bias negatives before the arithmetic shift
   assign acc_h  = acc + (acc[AccW-1] ? $signed(HistBias) : $signed({AccW{1'b0}}));
   assign acc_y  = acc + (acc[AccW-1] ? $signed(OutBias) : $signed({AccW{1'b0}}));
   assign q_hist = acc_h >>> COEF_FRAC_BITS;
   assign q_out  = acc_y >>> YShift;

   assign hist_top = q_hist[AccW-1:HW-1];
   assign out_top  = q_out[AccW-1:SW-1];
   assign hist_ok  = (&hist_top) || (~|hist_top);
   assign out_ok   = (&out_top) || (~|out_top);

   always_comb begin
      if (hist_ok) begin
         hist_sat = q_hist[HW-1:0];
      end else begin
         hist_sat = q_hist[AccW-1] ? bqn_pkg::HIST_MIN : bqn_pkg::HIST_MAX;
      end
      if (out_ok) begin
         sample_y = q_out[SW-1:0];
      end else begin
         sample_y = q_out[AccW-1] ? bqn_pkg::SAMPLE_MIN : bqn_pkg::SAMPLE_MAX;
      end
   end

   assign clipped = !hist_ok || !out_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         past_in_one_ff  <= '0;
         past_in_two_ff  <= '0;
         past_out_one_ff <= '0;
         past_out_two_ff <= '0;
      end else if (step.advance) begin
         past_in_one_ff  <= sample_x;
         past_in_two_ff  <= x1_eff;
         past_out_one_ff <= hist_sat;
         past_out_two_ff <= y1_eff;
      end
   end

   `ASSERT_NEXT(a_clear_in_two, clock, reset, step.advance && step.clear, past_in_two_ff == '0)
   `ASSERT_NEXT(a_hist_hold, clock, reset, !step.advance, $stable(past_out_one_ff) && $stable(past_out_two_ff))
   `ASSERT_NEXT(a_out_shift, clock, reset, step.advance, past_out_two_ff == $past(y1_eff))

endmodule

>>> rtl/biquad_notch_filter.sv
// Pipeline: an accepted beat is registered in s1, then moves into the rsp register once out_take allows.
// Throughput: one beat per cycle while rsp_ready does not stall the output; the feedback path
// (multiply, sum, truncate, saturate) is combinational from the history registers.
// Reset: synchronous, active high; clears history, valids, and loads
// coefficients with b0 = 1.0 (or the largest value if 1.0 does not fit) and all others zero.
`include "assert_macros.svh"

module biquad_notch_filter #(
   parameter int COEF_FRAC_BITS = bqn_pkg::DEF_COEF_FRAC_BITS,
   parameter int HIST_FRAC_BITS = bqn_pkg::DEF_HIST_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [bqn_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic                                 req_block_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [bqn_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   output logic                                 rsp_clipped,
   input  logic                                 csr_write_enable,
   input  logic [bqn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bqn_pkg::COEF_W-1:0]           csr_data
);

   bqn_pkg::coef_set_type coefs;
   bqn_pkg::step_ctl_type step;

   logic                                s1_valid_ff, s1_valid_in;
   logic signed [bqn_pkg::SAMPLE_W-1:0] s1_sample_ff;
   logic                                s1_start_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [bqn_pkg::SAMPLE_W-1:0] rsp_sample_ff;
   logic                                rsp_clipped_ff;
   logic signed [bqn_pkg::SAMPLE_W-1:0] core_y;
   logic                                core_clipped;
   logic                                out_take;

   bqn_coef_regs #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_coef_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .coefs            (coefs)
   );

   assign out_take     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = !s1_valid_ff || out_take;
   assign step.advance = s1_valid_ff && out_take;
   assign step.clear   = s1_start_ff;
   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_take ? s1_valid_ff : rsp_valid_ff;

   bqn_core #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .HIST_FRAC_BITS(HIST_FRAC_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .coefs    (coefs),
      .step     (step),
      .sample_x (s1_sample_ff),
      .sample_y (core_y),
      .clipped  (core_clipped)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_sample_ff <= req_sample_in;
         s1_start_ff  <= req_block_start;
      end
      if (step.advance) begin
         rsp_sample_ff  <= core_y;
         rsp_clipped_ff <= core_clipped;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

   `ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && req_ready, s1_valid_ff)
   `ASSERT_NEXT(a_drain_empty, clock, reset, rsp_valid_ff && rsp_ready && !s1_valid_ff, !rsp_valid_ff)
   `ASSERT_NEXT(a_advance_shows, clock, reset, step.advance, rsp_valid_ff)

endmodule
